>>> design/cre_pkg.sv
// ----------------------------------------------------------------------------
// cre_pkg
// Shared types and constants of the closure relation evaluator pipeline.
// ----------------------------------------------------------------------------
package cre_pkg;

  // Closure selection held in the mode register.
  typedef enum logic [1:0] {
    MODE_HNC  = 2'd0,
    MODE_KH   = 2'd1,
    MODE_PY   = 2'd2,
    MODE_INIT = 2'd3
  } cre_mode_e;

  // Configuration register index.
  typedef enum logic {
    CFG_BETA = 1'b0,
    CFG_MODE = 1'b1
  } cre_cfg_e;

  localparam logic [31:0] BETA_RESET = 32'd65536;

  // ln2 in Q32, exp argument limits in Q16.16, reciprocal 2^16/ln2 rounded up.
  localparam logic signed [34:0] LN2_Q32   = 35'sd2977044472;
  localparam logic signed [48:0] EXP_HIGH  = 49'sd1441792;
  localparam logic signed [48:0] EXP_LOW   = -49'sd786432;
  localparam logic signed [39:0] INV_LN2   = 40'sd94549;
  localparam logic [30:0]        Q30_ONE   = 31'h4000_0000;
  localparam logic signed [49:0] Q16_ONE   = 50'sd65536;

  // Per-request context carried down the pipeline.
  typedef struct packed {
    logic signed [31:0] t;      // indirect correlation
    logic signed [47:0] negbv;  // -beta*v, Q16.16
    logic               xpos;   // x > 0
    logic               cap;    // exp argument at or above the high limit
    logic               zero;   // exp argument at or below the low limit
    logic signed [6:0]  k;      // range reduction exponent
    logic [29:0]        r;      // reduced argument, Q30
    logic [30:0]        acc;    // Horner accumulator, Q30
  } cre_item_t;

endpackage

>>> design/cre_ifs.sv
// ----------------------------------------------------------------------------
// cre request / result channels
// Valid/ready channels carrying one sample in and one closure value out.
// ----------------------------------------------------------------------------
interface cre_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] potential;
  logic signed [31:0] indirect_corr;

  modport source (output valid, potential, indirect_corr, input ready);
  modport sink   (input valid, potential, indirect_corr, output ready);
endinterface

interface cre_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] direct_corr;
  logic               saturated;

  modport source (output valid, direct_corr, saturated, input ready);
  modport sink   (input valid, direct_corr, saturated, output ready);
endinterface

>>> design/cre_front.sv
// ----------------------------------------------------------------------------
// cre_front
// beta*v product, x formation, range checks and ln2 range reduction.
// ----------------------------------------------------------------------------
module cre_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         beta_i,
  input  cre_pkg::cre_mode_e  mode_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  potential_i,
  input  logic signed [31:0]  indirect_corr_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cre_pkg::cre_item_t  item_o
);
  import cre_pkg::*;

  localparam int unsigned NumStages = 6;

  logic [NumStages-1:0] vld_q, adv, vld_in;

  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int s = NumStages - 2; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end

  assign vld_in      = {vld_q[NumStages-2:0], in_valid_i};
  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int s = 0; s < NumStages; s++) begin
        if (adv[s]) vld_q[s] <= vld_in[s];
      end
    end
  end

  // stage 0: |v| * beta
  logic [31:0] vm_d;
  logic [63:0] prod_d;
  logic [62:0] prod_q;
  logic        vneg_q;
  logic signed [31:0] t0_q;

  assign vm_d   = potential_i[31] ? 32'(-potential_i) : 32'(potential_i);
  assign prod_d = 64'(beta_i) * 64'(vm_d);

  // stage 1: round to Q16.16, apply sign
  logic [62:0]        rnd_d;
  logic [46:0]        bvm_d;
  logic signed [47:0] negbv_d, negbv1_q;
  logic signed [31:0] t1_q;

  assign rnd_d   = prod_q + 63'd32768;
  assign bvm_d   = rnd_d[62:16];
  assign negbv_d = vneg_q ? $signed({1'b0, bvm_d}) : -$signed({1'b0, bvm_d});

  // stage 2: x, exp argument and its limits
  logic signed [48:0] x_d, y_d;
  cre_item_t          it2_d, it2_q;
  logic signed [21:0] y2_q;

  always_comb begin
    x_d = 49'(t1_q) + 49'(negbv1_q);
    y_d = (mode_i == MODE_PY || mode_i == MODE_INIT) ? 49'(negbv1_q) : x_d;
    it2_d       = '0;
    it2_d.t     = t1_q;
    it2_d.negbv = negbv1_q;
    it2_d.xpos  = x_d > 49'sd0;
    it2_d.cap   = y_d >= EXP_HIGH;
    it2_d.zero  = y_d <= EXP_LOW;
  end

  // stage 3: estimate k = floor(y / ln2)
  logic signed [39:0] kp_d;
  cre_item_t          it3_d, it3_q;
  logic signed [21:0] y3_q;

  always_comb begin
    kp_d    = 40'(y2_q) * INV_LN2;
    it3_d   = it2_q;
    it3_d.k = kp_d[38:32];
  end

  // stage 4: remainder r0 = y - k*ln2 in Q32
  logic signed [41:0] yq_d, kl_d, r0_d;
  logic signed [34:0] r4_q;
  cre_item_t          it4_q;

  assign yq_d = 42'($signed({y3_q, 16'b0}));
  assign kl_d = 42'(it3_q.k) * 42'(LN2_Q32);
  assign r0_d = yq_d - kl_d;

  // stage 5: one-step correction of the estimate
  logic signed [34:0] r5_d;
  cre_item_t          it5_d, it5_q;

  always_comb begin
    it5_d = it4_q;
    r5_d  = r4_q;
    if (r4_q < 35'sd0) begin
      r5_d    = r4_q + LN2_Q32;
      it5_d.k = it4_q.k - 7'sd1;
    end else if (r4_q >= LN2_Q32) begin
      r5_d    = r4_q - LN2_Q32;
      it5_d.k = it4_q.k + 7'sd1;
    end
    it5_d.r   = r5_d[31:2];
    it5_d.acc = Q30_ONE;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      prod_q <= prod_d[62:0];
      vneg_q <= potential_i[31];
      t0_q   <= indirect_corr_i;
    end
    if (adv[1]) begin
      negbv1_q <= negbv_d;
      t1_q     <= t0_q;
    end
    if (adv[2]) begin
      it2_q <= it2_d;
      y2_q  <= y_d[21:0];
    end
    if (adv[3]) begin
      it3_q <= it3_d;
      y3_q  <= y2_q;
    end
    if (adv[4]) begin
      it4_q <= it3_q;
      r4_q  <= r0_d[34:0];
    end
    if (adv[5]) begin
      it5_q <= it5_d;
    end
  end

  assign item_o = it5_q;

endmodule

>>> design/cre_horner.sv
// ----------------------------------------------------------------------------
// cre_horner
// One Horner step of the exp polynomial: acc = 1 + (acc*r)/Divisor, Q30.
// ----------------------------------------------------------------------------
module cre_horner #(
  parameter int unsigned Divisor = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cre_pkg::cre_item_t item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cre_pkg::cre_item_t item_o
);
  import cre_pkg::*;

  localparam int unsigned NumStages = 3;
  localparam logic [32:0] Recip     = 33'((64'd1 << 32) / Divisor);

  logic [NumStages-1:0] vld_q, adv, vld_in;

  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int s = NumStages - 2; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end

  assign vld_in      = {vld_q[NumStages-2:0], in_valid_i};
  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int s = 0; s < NumStages; s++) begin
        if (adv[s]) vld_q[s] <= vld_in[s];
      end
    end
  end

  // stage 0: product, truncated to Q30
  logic [60:0] p_d;
  logic [30:0] a0_q, a1_q;
  cre_item_t   it0_q, it1_q, it2_q;

  assign p_d = 61'(item_i.acc) * 61'(item_i.r);

  // stage 1: quotient estimate by reciprocal
  logic [63:0] qm_d;
  logic [30:0] qe1_q;

  assign qm_d = 64'(a0_q) * 64'(Recip);

  // stage 2: fix up the estimate, add one
  logic [33:0] qn_d, rem_d;
  logic [30:0] q_d;
  cre_item_t   it2_d;

  always_comb begin
    qn_d   = 34'(qe1_q) * 34'(Divisor);
    rem_d  = 34'(a1_q) - qn_d;
    q_d    = (rem_d >= 34'(Divisor)) ? qe1_q + 31'd1 : qe1_q;
    it2_d  = it1_q;
    it2_d.acc = Q30_ONE + q_d;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      a0_q  <= p_d[60:30];
      it0_q <= item_i;
    end
    if (adv[1]) begin
      qe1_q <= qm_d[62:32];
      a1_q  <= a0_q;
      it1_q <= it0_q;
    end
    if (adv[2]) begin
      it2_q <= it2_d;
    end
  end

  assign item_o = it2_q;

endmodule

>>> design/cre_back.sv
// ----------------------------------------------------------------------------
// cre_back
// 2^k scaling, PY product, closure select and Q16.16 clipping.
// ----------------------------------------------------------------------------
module cre_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cre_pkg::cre_mode_e  mode_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cre_pkg::cre_item_t  item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  direct_corr_o,
  output logic                saturated_o
);
  import cre_pkg::*;

  localparam int unsigned NumStages = 5;

  logic [NumStages-1:0] vld_q, adv, vld_in;

  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int s = NumStages - 2; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end

  assign vld_in      = {vld_q[NumStages-2:0], in_valid_i};
  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int s = 0; s < NumStages; s++) begin
        if (adv[s]) vld_q[s] <= vld_in[s];
      end
    end
  end

  // stage 0: e = acc * 2^(k-14), rounded half up
  logic signed [6:0] amt_s;
  logic [5:0]        amt_d;
  logic [48:0]       half_d, sum_d, e_d;
  logic [48:0]       e0_q;
  cre_item_t         it0_q, it1_q, it2_q, it3_q;

  always_comb begin
    amt_s  = 7'sd31 - item_i.k;
    amt_d  = amt_s[5:0];
    half_d = (amt_d == 6'd0) ? 49'd0 : (49'd1 << (amt_d - 6'd1));
    sum_d  = 49'({item_i.acc, 17'b0}) + half_d;
    e_d    = sum_d >> amt_d;
    if (item_i.cap)       e_d = 49'd1 << 48;
    else if (item_i.zero) e_d = 49'd0;
  end

  // stage 1: m = expm1, u = 1 + t, magnitudes
  logic signed [49:0] m_d, m1_q, m2_q, m3_q;
  logic signed [33:0] u_d;
  logic [48:0]        mm_d, mm1_q;
  logic [31:0]        um_d, um1_q;
  logic               neg1_q, neg2_q, neg3_q;

  always_comb begin
    m_d  = $signed({1'b0, e0_q}) - Q16_ONE;
    u_d  = 34'(it0_q.t) + 34'sd65536;
    mm_d = m_d[49] ? 49'(-m_d) : 49'(m_d);
    um_d = u_d[33] ? 32'(-u_d) : 32'(u_d);
  end

  // stage 2: split product
  logic [56:0] pl_d, pl2_q;
  logic [55:0] ph_d, ph2_q;

  assign pl_d = 57'(mm1_q[24:0]) * 57'(um1_q);
  assign ph_d = 56'(mm1_q[48:25]) * 56'(um1_q);

  // stage 3: sum and round PY product; HNC difference
  logic [80:0]        pr_d;
  logic [64:0]        q3_q;
  logic signed [50:0] rc_d, rc3_q;

  assign pr_d = 81'(pl2_q) + {ph2_q, 25'b0} + 81'd32768;
  assign rc_d = 51'(m2_q) - 51'(it2_q.t);

  // stage 4: closure select and clip
  logic signed [66:0] res_d;
  logic signed [66:0] qs_d;
  logic signed [31:0] dc_d, dc_q;
  logic               sat_d, sat_q;

  always_comb begin
    qs_d = $signed({2'b0, q3_q});
    case (mode_i)
      MODE_INIT: res_d = 67'(m3_q);
      MODE_PY:   res_d = neg3_q ? -qs_d : qs_d;
      MODE_KH:   res_d = it3_q.xpos ? 67'(it3_q.negbv) : 67'(rc3_q);
      MODE_HNC:  res_d = 67'(rc3_q);
    endcase
    sat_d = 1'b1;
    if (res_d > 67'sd2147483647)        dc_d = 32'sh7fff_ffff;
    else if (res_d < -67'sd2147483648)  dc_d = 32'sh8000_0000;
    else begin
      dc_d  = res_d[31:0];
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      e0_q  <= e_d;
      it0_q <= item_i;
    end
    if (adv[1]) begin
      m1_q   <= m_d;
      mm1_q  <= mm_d;
      um1_q  <= um_d;
      neg1_q <= m_d[49] ^ u_d[33];
      it1_q  <= it0_q;
    end
    if (adv[2]) begin
      pl2_q  <= pl_d;
      ph2_q  <= ph_d;
      m2_q   <= m1_q;
      neg2_q <= neg1_q;
      it2_q  <= it1_q;
    end
    if (adv[3]) begin
      q3_q   <= pr_d[80:16];
      rc3_q  <= rc_d;
      m3_q   <= m2_q;
      neg3_q <= neg2_q;
      it3_q  <= it2_q;
    end
    if (adv[4]) begin
      dc_q  <= dc_d;
      sat_q <= sat_d;
    end
  end

  assign direct_corr_o = dc_q;
  assign saturated_o   = sat_q;

endmodule

>>> design/closure_relation_evaluator_unit.sv
// ----------------------------------------------------------------------------
// closure_relation_evaluator_unit
// Streaming HNC / KH / PY / INIT closure evaluator on signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Takes one request per clock (potential v, indirect correlation t) unless
// the result side stalls, and returns one direct correlation c per request,
// in order. Throughput is one sample per cycle while the result side is not
// stalled. The pipeline has 6 front stages (beta*v, x, ln2 range
// reduction), 7 Horner steps of 3 stages each (multiply, reciprocal
// divide, fix-up) and 5 back stages (2^k scaling, PY product in two
// partial products, select and clip). Every stage carries its own valid
// bit and only waits when the stage after it is full and cannot advance,
// so bubbles close up under back-pressure. Write inverse_temperature and
// closure_mode only while no request is in flight.
// ----------------------------------------------------------------------------
module closure_relation_evaluator_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  cre_pkg::cre_cfg_e cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  cre_req_if.sink           req_i,
  cre_rsp_if.source         rsp_o
);
  import cre_pkg::*;

  localparam int unsigned NumSteps = 7;

  // configuration registers
  logic [31:0] beta_q, beta_d;
  cre_mode_e   mode_q, mode_d;

  always_comb begin
    beta_d = beta_q;
    mode_d = mode_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BETA: beta_d = cfg_data_i;
        CFG_MODE: mode_d = cre_mode_e'(cfg_data_i[1:0]);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= BETA_RESET;
      mode_q <= MODE_HNC;
    end else begin
      beta_q <= beta_d;
      mode_q <= mode_d;
    end
  end

  // valid/ready chain between the parts
  logic      hv [NumSteps+1];
  logic      hr [NumSteps+1];
  cre_item_t hit[NumSteps+1];

  cre_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .beta_i          (beta_q),
    .mode_i          (mode_q),
    .in_valid_i      (req_i.valid),
    .in_ready_o      (req_i.ready),
    .potential_i     (req_i.potential),
    .indirect_corr_i (req_i.indirect_corr),
    .out_valid_o     (hv[0]),
    .out_ready_i     (hr[0]),
    .item_o          (hit[0])
  );

  // Horner terms from degree 7 down to 1
  for (genvar i = 0; i < NumSteps; i++) begin : g_horner
    cre_horner #(
      .Divisor (NumSteps - i)
    ) u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (hv[i]),
      .in_ready_o  (hr[i]),
      .item_i      (hit[i]),
      .out_valid_o (hv[i+1]),
      .out_ready_i (hr[i+1]),
      .item_o      (hit[i+1])
    );
  end

  cre_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_q),
    .in_valid_i    (hv[NumSteps]),
    .in_ready_o    (hr[NumSteps]),
    .item_i        (hit[NumSteps]),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .direct_corr_o (rsp_o.direct_corr),
    .saturated_o   (rsp_o.saturated)
  );

endmodule
